[rtl/psk_pkg.sv]
`default_nettype none

package psk_pkg;

	localparam int MAX_KEY_LEN_DEF   = 64;
	localparam int MAX_POSITIONS_DEF = 8;

	localparam int CHAR_W    = 8;
	localparam int HASH_W    = 26;
	localparam int TSIZE_W   = 20;
	localparam int PLIST_W   = 64;
	localparam int PCNT_W    = 4;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LIST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_COUNT = 2'd2;

	localparam int HASH_MUL   = 13;
	localparam int CHAR_MOD   = 29;
	// floor(c/29) == (c*565) >> 14 for every 8-bit c
	localparam int MOD_RECIP  = 565;
	localparam int MOD_SHIFT  = 14;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_FOLD,
		ST_DSTART,
		ST_DIV,
		ST_DONE
	} psk_state_t;

	function automatic logic [4:0] mod29(input logic [CHAR_W-1:0] c);
		logic [17:0] prod;
		logic [3:0]  quot;
		logic [CHAR_W-1:0] rem;
		prod = 18'(c) * 18'(MOD_RECIP);
		quot = prod[17:MOD_SHIFT];
		rem  = c - CHAR_W'(8'(quot) * 8'(CHAR_MOD));
		return rem[4:0];
	endfunction

	function automatic logic [HASH_W-1:0] hash_fold(input logic [HASH_W-1:0] h,
		input logic [4:0] r);
		return HASH_W'((h << 3) + (h << 2) + h + HASH_W'(r));
	endfunction

endpackage

`default_nettype wire

[rtl/psk_key_store.sv]
`default_nettype none

module psk_key_store #(
	parameter int DEPTH = psk_pkg::MAX_KEY_LEN_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [psk_pkg::CHAR_W-1:0] wdata,
	input  wire logic [AW-1:0]             raddr,
	output logic      [psk_pkg::CHAR_W-1:0] rdata
);
	import psk_pkg::*;

	logic [CHAR_W-1:0] mem_q [DEPTH];
	logic [CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/psk_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module psk_div #(
	parameter int NW = psk_pkg::HASH_W,
	parameter int DW = psk_pkg::TSIZE_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      remainder
);
	import psk_pkg::*;

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   num_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[rtl/position_select_key_hash_core.sv]
// Position-selected key hash.
// Input channel (in_valid/in_ready): one key character per beat, last_char
// marks the final one. Characters that do not end a key are taken one per
// cycle. A key longer than MAX_KEY_LEN keeps its first MAX_KEY_LEN characters
// and reports key_too_long.
// On the final character the sequencer walks up to MAX_POSITIONS configured
// positions (store read, then fold through the shared multiply-add), and
// then runs a bit-serial divider for hash mod table_size (one iteration per
// hash bit, skipped when table_size is zero). in_ready is low from the final
// beat until the result is loaded into the output register.
// Output channel (out_valid/out_ready): a result register holds one beat.
// While it waits, new key characters are still taken; a further final
// character is worked on and held until the receiver takes the pending beat.
// Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle;
// the core does not enforce it. Reset clears the key length, the overflow
// flag, the configuration registers and both channels.
`default_nettype none

module position_select_key_hash_core #(
	parameter int MAX_KEY_LEN   = psk_pkg::MAX_KEY_LEN_DEF,
	parameter int MAX_POSITIONS = psk_pkg::MAX_POSITIONS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [psk_pkg::CHAR_W-1:0]     char_code,
	input  wire logic                           last_char,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [psk_pkg::HASH_W-1:0]     hash_value,
	output logic      [psk_pkg::TSIZE_W-1:0]    bucket,
	output logic                                table_empty,
	output logic                                key_too_long,
	input  wire logic                           cfg_we,
	input  wire logic [psk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [psk_pkg::CFG_W-1:0]      cfg_data
);
	import psk_pkg::*;

	localparam int AW = $clog2(MAX_KEY_LEN);
	localparam int LW = $clog2(MAX_KEY_LEN + 1);
	localparam int CW = $clog2(MAX_POSITIONS + 1);

	psk_state_t state_q, state_d;

	logic [TSIZE_W-1:0] table_size_q;
	logic [PLIST_W-1:0] pos_list_q;
	logic [PCNT_W-1:0]  pos_cnt_q;

	logic [LW-1:0]      len_q;
	logic               ovf_q;
	logic [CW-1:0]      pos_i_q;
	logic [HASH_W-1:0]  hash_q;
	logic               use_q;
	logic               zero_q;

	logic               out_valid_q;
	logic [HASH_W-1:0]  hash_out_q;
	logic [TSIZE_W-1:0] bucket_q;
	logic               empty_q;
	logic               too_long_q;

	logic               in_acc;
	logic               store_we;
	logic [CW-1:0]      cnt_eff;
	logic [CHAR_W-1:0]  raw;
	logic [CHAR_W-1:0]  len8;
	logic [CHAR_W-1:0]  q_val;
	logic [CHAR_W-1:0]  idx8;
	logic               pos_use;
	logic               pos_zero;
	logic [AW-1:0]      raddr;
	logic [CHAR_W-1:0]  rdata;
	logic [CHAR_W-1:0]  char_sel;
	logic               out_load;
	logic [TSIZE_W-1:0] div_rem;
	logic               div_start;
	logic               div_done;

	assign in_acc   = in_valid && in_ready;
	assign store_we = in_acc && (len_q < LW'(MAX_KEY_LEN));
	assign cnt_eff  = (pos_cnt_q > PCNT_W'(MAX_POSITIONS)) ? CW'(MAX_POSITIONS)
		: CW'(pos_cnt_q);

	// position decode for the current slot
	always_comb begin
		raw      = CHAR_W'(pos_list_q >> {pos_i_q, 3'b000});
		len8     = CHAR_W'(len_q);
		pos_use  = 1'b1;
		pos_zero = 1'b0;
		q_val    = '0;
		idx8     = '0;
		if (raw == '0) begin
			pos_zero = 1'b1;
		end else if (raw[CHAR_W-1]) begin
			q_val    = ~raw;
			pos_use  = q_val < len8;
			idx8     = len8 - q_val;
			pos_zero = (q_val == '0);  // index equal to length reads 0
		end else begin
			q_val   = raw - 1'b1;
			pos_use = q_val < len8;
			idx8    = q_val;
		end
	end

	assign raddr    = AW'(idx8);
	assign char_sel = zero_q ? '0 : rdata;

	psk_key_store #(
		.DEPTH (MAX_KEY_LEN),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (AW'(len_q)),
		.wdata (char_code),
		.raddr (raddr),
		.rdata (rdata)
	);

	psk_div #(
		.NW (HASH_W),
		.DW (TSIZE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (hash_q),
		.divisor   (table_size_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && last_char) begin
					state_d = (cnt_eff == '0) ? ST_DSTART : ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_FOLD;
			end
			ST_FOLD: begin
				state_d = (pos_i_q + 1'b1 == cnt_eff) ? ST_DSTART : ST_RD;
			end
			ST_DSTART: begin
				if (table_size_q != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
			pos_list_q   <= '0;
			pos_cnt_q    <= '0;
			len_q        <= '0;
			ovf_q        <= 1'b0;
			pos_i_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TABLE_SIZE:     table_size_q <= cfg_data[TSIZE_W-1:0];
					CFG_POSITION_LIST:  pos_list_q   <= cfg_data[PLIST_W-1:0];
					CFG_POSITION_COUNT: pos_cnt_q    <= cfg_data[PCNT_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				if (store_we) begin
					len_q <= len_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				pos_i_q <= '0;
			end
			if (state_q == ST_FOLD) begin
				pos_i_q <= pos_i_q + 1'b1;
			end
			if (out_load) begin
				len_q       <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hash_q <= '0;
		end
		if (state_q == ST_RD) begin
			use_q  <= pos_use;
			zero_q <= pos_zero;
		end
		if (state_q == ST_FOLD && use_q) begin
			hash_q <= hash_fold(hash_q, mod29(char_sel));
		end
		if (out_load) begin
			hash_out_q <= hash_q;
			empty_q    <= (table_size_q == '0);
			bucket_q   <= (table_size_q == '0) ? '0 : div_rem;
			too_long_q <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hash_value   = hash_out_q;
	assign bucket       = bucket_q;
	assign table_empty  = empty_q;
	assign key_too_long = too_long_q;

endmodule

`default_nettype wire

[verif/position_select_key_hash_core_tb.sv]
`default_nettype none

module position_select_key_hash_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psk_pkg::*;

	localparam int KEY_DEPTH = MAX_KEY_LEN_DEF;
	localparam int POS_SLOTS = MAX_POSITIONS_DEF;
	// index 3 is not decoded; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD = 300;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic [HASH_W-1:0]  hash;
		logic [TSIZE_W-1:0] bkt;
		logic               empty;
		logic               too_long;
	} hash_beat_t;

	class key_hash_scoreboard;
		logic [CHAR_W-1:0]  chars [KEY_DEPTH];
		int unsigned        key_len;
		bit                 overflow;
		logic [TSIZE_W-1:0] tsize;
		logic [PLIST_W-1:0] plist;
		logic [PCNT_W-1:0]  pcount;
		hash_beat_t         expected_hashes[$];
		int                 errors;

		function new();
			key_len = 0;
			overflow = 0;
			tsize = '0;
			plist = '0;
			pcount = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_TABLE_SIZE:     tsize = data[TSIZE_W-1:0];
				CFG_POSITION_LIST:  plist = data[PLIST_W-1:0];
				CFG_POSITION_COUNT: pcount = data[PCNT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [HASH_W-1:0] select_hash();
			logic [HASH_W-1:0] h;
			logic [7:0]        raw;
			logic [7:0]        q;
			logic [CHAR_W-1:0] c;
			int unsigned       n;
			int unsigned       idx;
			bit                hit;
			h = '0;
			n = (pcount > POS_SLOTS) ? POS_SLOTS : pcount;
			for (int i = 0; i < n; i++) begin
				raw = plist[8*i +: 8];
				hit = 1;
				c = '0;
				if (raw[7]) begin
					// counted from the end; index l reads as zero
					q = ~raw;
					hit = q < key_len;
					idx = key_len - q;
					if (hit && idx < key_len)
						c = chars[idx];
				end else if (raw != 8'd0) begin
					q = raw - 8'd1;
					hit = q < key_len;
					if (hit)
						c = chars[q];
				end
				if (hit)
					h = HASH_W'(h * HASH_MUL + c % CHAR_MOD);
			end
			return h;
		endfunction

		function void note_char(logic [CHAR_W-1:0] ch, logic last);
			hash_beat_t e;
			if (key_len < KEY_DEPTH) begin
				chars[key_len] = ch;
				key_len++;
			end else
				overflow = 1;
			if (last) begin
				e.hash = select_hash();
				e.bkt = (tsize != 0) ? TSIZE_W'(e.hash % tsize) : '0;
				e.empty = (tsize == 0);
				e.too_long = overflow;
				expected_hashes.push_back(e);
				key_len = 0;
				overflow = 0;
			end
		endfunction

		function void check_result(hash_beat_t got);
			hash_beat_t e;
			if (expected_hashes.size() == 0) begin
				$display("%0t: unexpected result beat, hash %0h", $time, got.hash);
				errors++;
				return;
			end
			e = expected_hashes.pop_front();
			if (got.hash !== e.hash) begin
				$display("%0t: hash_value mismatch, expected %0h actual %0h",
					$time, e.hash, got.hash);
				errors++;
			end
			if (got.bkt !== e.bkt) begin
				$display("%0t: bucket mismatch, expected %0d actual %0d",
					$time, e.bkt, got.bkt);
				errors++;
			end
			if (got.empty !== e.empty) begin
				$display("%0t: table_empty mismatch, expected %0b actual %0b",
					$time, e.empty, got.empty);
				errors++;
			end
			if (got.too_long !== e.too_long) begin
				$display("%0t: key_too_long mismatch, expected %0b actual %0b",
					$time, e.too_long, got.too_long);
				errors++;
			end
		endfunction

		function int pending();
			return expected_hashes.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CHAR_W-1:0]    char_code;
	logic                 last_char;
	logic                 out_valid;
	logic                 out_ready;
	logic [HASH_W-1:0]    hash_value;
	logic [TSIZE_W-1:0]   bucket;
	logic                 table_empty;
	logic                 key_too_long;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	key_hash_scoreboard sb;
	bit sender_burst;
	int key_count;

	position_select_key_hash_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hash_value(hash_value),
		.bucket(bucket),
		.table_empty(table_empty),
		.key_too_long(key_too_long),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [TSIZE_W-1:0] ts, input logic [PLIST_W-1:0] pl,
		input logic [PCNT_W-1:0] pc, input bit touch_unused);
		logic [CFG_W-1:0] junk;
		junk = {$urandom, $urandom};
		write_reg(CFG_TABLE_SIZE, {junk[CFG_W-1:TSIZE_W], ts});
		write_reg(CFG_POSITION_LIST, pl);
		write_reg(CFG_POSITION_COUNT, {junk[CFG_W-1:PCNT_W], pc});
		if (touch_unused)
			write_reg(CFG_UNUSED, junk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= ch;
		last_char <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_char(ch, last);
		@(negedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'hff;
			2: return CHAR_W'($urandom_range(27, 30));
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly short positions so they land inside short keys
	function automatic logic [PLIST_W-1:0] pick_positions();
		logic [PLIST_W-1:0] pl;
		for (int i = 0; i < POS_SLOTS; i++)
			if ($urandom_range(0, 3) == 0)
				pl[8*i +: 8] = 8'($urandom_range(0, 255));
			else
				pl[8*i +: 8] = 8'($urandom_range(0, 26) - 13);
		return pl;
	endfunction

	task automatic send_key(input int len);
		sender_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++)
			send_char(pick_char(), i == len - 1);
		key_count++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// receiver
	initial begin
		int hold;
		int beats_out;
		bit rx_burst;
		hash_beat_t got;
		out_ready = 1'b0;
		beats_out = 0;
		rx_burst = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 11) == 0)
				rx_burst = !rx_burst;
			if (beats_out == 30 || beats_out == 100)
				hold = LONG_HOLD;
			else
				hold = rx_burst ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.hash = hash_value;
			got.bkt = bucket;
			got.empty = table_empty;
			got.too_long = key_too_long;
			sb.check_result(got);
			beats_out++;
			@(negedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [TSIZE_W-1:0] ts;
		logic [PLIST_W-1:0] pl;
		logic [PCNT_W-1:0]  pc;
		int items;
		int len;
		sb = new();
		key_count = 0;
		sender_burst = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		last_char = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// positions 1, -1, 0, 127, -128, 64, -64, 2
		load_settings(20'hfffff, 64'h02_c0_40_80_7f_00_ff_01, 4'd8, 0);
		send_char(8'hff, 1'b1);
		send_char(8'h00, 1'b1);
		send_char(8'd29, 1'b0);
		send_char(8'd28, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'd57, 1'b1);
		wait_idle();

		// empty table, count above the slot number, every position -1
		load_settings(20'd0, 64'hffff_ffff_ffff_ffff, 4'd15, 1);
		send_char(8'd100, 1'b0);
		send_char(8'd200, 1'b1);
		send_char(8'hff, 1'b1);
		wait_idle();

		load_settings(20'd1, 64'h0123_4567_89ab_cdef, 4'd0, 0);
		send_char(8'd7, 1'b1);
		wait_idle();

		// zero position alone
		load_settings(20'd12345, 64'h7f7f_7f7f_7f7f_7f00, 4'd1, 0);
		send_char(8'd1, 1'b0);
		send_char(8'd2, 1'b1);
		wait_idle();

		// positions past the end of the key
		load_settings(20'd7, 64'h7f7f_7f7f_7f7f_7f7f, 4'd8, 0);
		send_char(8'd1, 1'b0);
		send_char(8'd2, 1'b0);
		send_char(8'd3, 1'b1);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 6)
				0: ts = 20'd0;
				1: ts = 20'd1;
				2: ts = 20'hfffff;
				default: ts = TSIZE_W'($urandom_range(2, 20'hfffff));
			endcase
			case (p % 5)
				0: pc = 4'd8;
				1: pc = PCNT_W'($urandom_range(9, 15));
				2: pc = (p == 2) ? 4'd0 : 4'd8;
				default: pc = PCNT_W'($urandom_range(1, 8));
			endcase
			case (p % 4)
				0: pl = {$urandom, $urandom};
				1: pl = (p == 1) ? 64'h8080_8080_8080_8080 : pick_positions();
				default: pl = pick_positions();
			endcase
			load_settings(ts, pl, pc, p == 5);
			items = 0;
			while (items < PHASE_ITEMS) begin
				// every twentieth key runs around the store depth
				if (key_count % 20 == 7)
					len = $urandom_range(KEY_DEPTH - 2, KEY_DEPTH + 4);
				else
					len = $urandom_range(1, 12);
				send_key(len);
				items += len;
			end
			wait_idle();
		end

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
